// ===== design/csat_pkg.sv =====
package csat_pkg;

  localparam int DATA_W = 20;
  localparam int TGT_W  = 24;
  localparam int DIST_W = 24;
  // an element with k one bits gives at most k+1 distinct run ANDs
  localparam int DEPTH  = DATA_W + 1;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DIFF_W = ((DATA_W > TGT_W) ? DATA_W : TGT_W) + 1;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef struct packed {
    logic             load;
    logic             insert;
    logic             walk;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic             finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] set_count;
    logic             last;
    logic             out_free;
  } dp_sts_t;

  // |v - t|, saturated to the distance width
  function automatic logic [DIST_W-1:0] dist_f(input logic [DATA_W-1:0] v,
                                               input logic [TGT_W-1:0]  t);
    logic [DIFF_W-1:0] a;
    logic [DIFF_W-1:0] b;
    logic [DIFF_W-1:0] d;
    a = DIFF_W'(v);
    b = DIFF_W'(t);
    d = (a >= b) ? (a - b) : (b - a);
    if (d > DIFF_W'(DIST_MAX)) begin
      return DIST_MAX;
    end
    return d[DIST_W-1:0];
  endfunction

endpackage

// ===== design/csat_if.sv =====
interface csat_in_if;
  logic                         valid;
  logic                         ready;
  logic [csat_pkg::DATA_W-1:0]  element;
  logic                         end_of_array;

  modport source (output valid, output element, output end_of_array, input ready);
  modport sink   (input valid, input element, input end_of_array, output ready);
endinterface

interface csat_out_if;
  logic                         valid;
  logic                         ready;
  logic [csat_pkg::DIST_W-1:0]  min_distance;

  modport source (output valid, output min_distance, input ready);
  modport sink   (input valid, input min_distance, output ready);
endinterface

interface csat_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [csat_pkg::TGT_W-1:0]   target_value;

  modport source (output valid, output target_value, input ready);
  modport sink   (input valid, input target_value, output ready);
endinterface

// ===== design/closest_subarray_and_to_target.sv =====
// Channel | Dir | Payload                      | Transaction when
// cfg_i   | in  | target_value[23:0]           | valid && ready (ready always high)
// in_i    | in  | element[19:0], end_of_array  | valid && ready
// out_o   | out | min_distance[23:0]           | valid && ready, one per array
//
// An element passes through accept, insert of the element, a walk over each
// stored run AND (up to 21, one memory read port), then commit. A new element
// is accepted only once the previous one has committed.
// Reset is async active low; it empties the set, sets the best distance to all
// ones and clears the target. The result sits in an output register; a stalled
// result only holds the block once the next array end is ready to commit.
module closest_subarray_and_to_target (
  input  logic       clk_i,
  input  logic       rst_ni,
  csat_cfg_if.sink   cfg_i,
  csat_in_if.sink    in_i,
  csat_out_if.source out_o
);
  import csat_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;
  logic      in_ready;

  // target register accepts a write at any time; the user must write it only when idle, the block does not enforce it
  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;

  // sequencer: accept / insert / walk the stored set / commit
  csat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // set memory, running minimum and output register
  csat_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .element_i          (in_i.element),
    .end_of_array_i     (in_i.end_of_array),
    .cfg_we_i           (cfg_i.valid),
    .cfg_target_i       (cfg_i.target_value),
    .out_valid_o        (out_o.valid),
    .out_ready_i        (out_o.ready),
    .out_min_distance_o (out_o.min_distance)
  );

endmodule

// ===== design/csat_ctrl.sv =====
module csat_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  csat_pkg::dp_sts_t    sts_i,
  output csat_pkg::ctrl_cmd_t  cmd_o
);
  import csat_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_INSERT = 2'd1;
  localparam logic [1:0] ST_WALK   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] idx_q, idx_d;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_INSERT;
        end
      end
      ST_INSERT: begin
        cmd_o.insert = 1'b1;
        if (sts_i.set_count != '0) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_idx = '0;
          idx_d        = CNT_W'(1);
          state_d      = ST_WALK;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_WALK: begin
        // read data of the previous issue is consumed here
        cmd_o.walk = 1'b1;
        if (idx_q < sts_i.set_count) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_idx = idx_q[IDX_W-1:0];
          idx_d        = idx_q + CNT_W'(1);
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!sts_i.last || sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

// ===== design/csat_dp.sv =====
module csat_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  csat_pkg::ctrl_cmd_t           cmd_i,
  output csat_pkg::dp_sts_t             sts_o,
  input  logic [csat_pkg::DATA_W-1:0]   element_i,
  input  logic                          end_of_array_i,
  input  logic                          cfg_we_i,
  input  logic [csat_pkg::TGT_W-1:0]    cfg_target_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [csat_pkg::DIST_W-1:0]   out_min_distance_o
);
  import csat_pkg::*;

  // two banks: the current set is read from one, the new set written to the other
  logic [DATA_W-1:0] mem [0:(2**(IDX_W+1))-1];

  logic [TGT_W-1:0]  target_q;
  logic [DATA_W-1:0] num_q;
  logic              last_q;
  logic [DATA_W-1:0] prev_q, prev_d;
  logic [DATA_W-1:0] rdata_q;
  logic [CNT_W-1:0]  n_q, n_d;
  logic [CNT_W-1:0]  set_count_q;
  logic              bank_q;
  logic [DIST_W-1:0] best_q;
  logic              out_valid_q;
  logic [DIST_W-1:0] out_data_q;

  logic [DATA_W-1:0] cand;
  logic [DIST_W-1:0] cand_dist;
  logic              wr_en;

  // chain of run ANDs only shrinks, so a duplicate always equals the last kept value
  always_comb begin
    cand   = cmd_i.insert ? num_q : (rdata_q & num_q);
    n_d    = n_q;
    prev_d = prev_q;
    wr_en  = 1'b0;
    if (cmd_i.insert) begin
      wr_en  = 1'b1;
      n_d    = CNT_W'(1);
      prev_d = num_q;
    end else if (cmd_i.walk && (cand != prev_q)) begin
      wr_en  = 1'b1;
      n_d    = n_q + CNT_W'(1);
      prev_d = cand;
    end
  end

  assign cand_dist = dist_f(cand, target_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[{~bank_q, (cmd_i.insert ? IDX_W'(0) : n_q[IDX_W-1:0])}] <= cand;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[{bank_q, cmd_i.rd_idx}];
    end
    if (cmd_i.load) begin
      num_q  <= element_i;
      last_q <= end_of_array_i;
    end
    prev_q <= prev_d;
    if (cmd_i.finish && last_q) begin
      out_data_q <= best_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= '0;
      n_q         <= '0;
      set_count_q <= '0;
      bank_q      <= 1'b0;
      best_q      <= DIST_MAX;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        target_q <= cfg_target_i;
      end
      n_q <= n_d;
      if ((cmd_i.insert || cmd_i.walk) && (cand_dist < best_q)) begin
        best_q <= cand_dist;
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.finish) begin
        bank_q <= ~bank_q;
        if (last_q) begin
          set_count_q <= '0;
          best_q      <= DIST_MAX;
          out_valid_q <= 1'b1;
        end else begin
          set_count_q <= n_q;
        end
      end
    end
  end

  assign sts_o.set_count    = set_count_q;
  assign sts_o.last         = last_q;
  assign sts_o.out_free     = !out_valid_q || out_ready_i;
  assign out_valid_o        = out_valid_q;
  assign out_min_distance_o = out_data_q;

endmodule

// ===== design/csat_chk.sv =====
module csat_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         in_last_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [csat_pkg::DIST_W-1:0]  out_data_i
);
  import csat_pkg::*;

  logic [1:0] owed_q;

  // array ends accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owed_q <= '0;
    end else begin
      owed_q <= owed_q + 2'(in_valid_i && in_ready_i && in_last_i)
                       - 2'(out_valid_i && out_ready_i);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("result changed while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> owed_q != 2'd0)
    else $error("result without an array end");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted back to back");

endmodule

bind closest_subarray_and_to_target csat_chk u_csat_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.end_of_array),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.min_distance)
);

// ===== dv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import csat_pkg::*;

  // Clock period and reset length.
  localparam int CLK_HALF = 4;
  localparam int RESET_CYCLES = 6;
  // Long enough for any element still in flight to finish its walk and commit.
  localparam int DRAIN_CYCLES = 32;
  // Cycles without any transaction before the run is declared hung.
  localparam int HANG_LIMIT = 3000;
  localparam int RANDOM_ITEMS = 1175;
  localparam int MAX_PRINTED = 40;

  // How the elements of one random array are drawn.
  typedef enum int {
    FILL_UNIFORM,  // any 20-bit value
    FILL_DENSE,    // all ones with a few bits knocked out, so the AND set grows deep
    FILL_NARROW,   // low byte only
    FILL_MIXED     // each element picks one of the above, plus all-zero and all-ones
  } fill_style_e;

  logic clk_i;
  logic rst_ni;

  csat_cfg_if cfg_bus();
  csat_in_if  elem_bus();
  csat_out_if dist_bus();

  closest_subarray_and_to_target DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_bus),
    .in_i  (elem_bus),
    .out_o (dist_bus)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: the ANDs of all runs that end at the latest element, the
  // best distance of the open array, and the target the block currently holds.
  // ---------------------------------------------------------------------------
  logic [DATA_W-1:0] run_ands[$];
  logic [DIST_W-1:0] best_dist;
  logic [TGT_W-1:0]  target_reg;
  // Distances still owed by the block, one per closed array, oldest first.
  logic [DIST_W-1:0] pending_min_dist[$];

  int mismatches;
  int elements_sent;
  int arrays_closed;
  int results_checked;
  int target_writes;
  int deepest_set;
  int burst_left;
  int quiet_cycles;

  // |v - target|, saturated to the width of the result.
  function automatic logic [DIST_W-1:0] distance_to_target(input logic [DATA_W-1:0] v);
    longint unsigned a;
    longint unsigned t;
    longint unsigned d;
    a = longint'(v);
    t = longint'(target_reg);
    d = (a >= t) ? (a - t) : (t - a);
    if (d > longint'(DIST_MAX)) begin
      d = longint'(DIST_MAX);
    end
    return d[DIST_W-1:0];
  endfunction

  function automatic void note_candidate(input logic [DATA_W-1:0] v);
    logic [DIST_W-1:0] d;
    d = distance_to_target(v);
    if (d < best_dist) begin
      best_dist = d;
    end
  endfunction

  // Folds one accepted element into the predicted state. On the last element of
  // an array the expected distance is queued and the array state cleared.
  function automatic void absorb_element(input logic [DATA_W-1:0] elem, input logic last);
    logic [DATA_W-1:0] next_ands[$];
    logic [DATA_W-1:0] v;
    bit seen;
    next_ands.push_back(elem);
    note_candidate(elem);
    foreach (run_ands[i]) begin
      v = run_ands[i] & elem;
      note_candidate(v);
      seen = 1'b0;
      foreach (next_ands[j]) begin
        if (next_ands[j] == v) begin
          seen = 1'b1;
        end
      end
      if (!seen) begin
        next_ands.push_back(v);
      end
    end
    run_ands = next_ands;
    if (run_ands.size() > deepest_set) begin
      deepest_set = run_ands.size();
    end
    if (last) begin
      pending_min_dist.push_back(best_dist);
      run_ands.delete();
      best_dist = DIST_MAX;
      arrays_closed++;
    end
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("ERROR @%0t: %s", $time, what);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock. Reset is asserted once, at the start of the test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever begin
      #CLK_HALF clk_i = ~clk_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Result side. ready follows its own pattern: segments of random length that
  // are always ready, coin-flip, mostly stalled, or ready on a regular phase pattern.
  // ---------------------------------------------------------------------------
  initial begin
    int seg_left;
    int seg_mode;
    int phase;
    seg_left = 0;
    seg_mode = 0;
    phase = 0;
    dist_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 200);
        seg_mode = $urandom_range(0, 3);
      end
      seg_left--;
      phase++;
      case (seg_mode)
        0: dist_bus.ready <= 1'b1;
        1: dist_bus.ready <= 1'($urandom_range(0, 1));
        2: dist_bus.ready <= ($urandom_range(0, 5) == 0);
        default: dist_bus.ready <= (phase % 4 == 0);
      endcase
    end
  end

  // Compares every result transaction with the oldest outstanding expectation.
  always @(posedge clk_i) begin
    if (rst_ni && dist_bus.valid && dist_bus.ready) begin
      if (pending_min_dist.size() == 0) begin
        report_mismatch($sformatf("result 0x%06h with no array pending", dist_bus.min_distance));
      end else begin
        if (dist_bus.min_distance !== pending_min_dist[0]) begin
          report_mismatch($sformatf("array %0d: min_distance 0x%06h, want 0x%06h",
                                    results_checked, dist_bus.min_distance,
                                    pending_min_dist[0]));
        end
        void'(pending_min_dist.pop_front());
        results_checked++;
      end
    end
  end

  // Watchdog: any transaction on any channel counts as progress.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((elem_bus.valid && elem_bus.ready) || (dist_bus.valid && dist_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= HANG_LIMIT) begin
        $display("ERROR @%0t: no transaction for %0d cycles, %0d results outstanding",
                 $time, HANG_LIMIT, pending_min_dist.size());
        $display("closest_subarray_and_to_target: mismatch");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------

  // Sends one element. The sender runs in bursts; between bursts valid drops
  // for a random gap (sometimes none). valid stays high on return so that a
  // back-to-back element needs no second assignment in the same step.
  task automatic send_element(input logic [DATA_W-1:0] elem, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        elem_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    elem_bus.valid        <= 1'b1;
    elem_bus.element      <= elem;
    elem_bus.end_of_array <= last;
    do begin
      @(posedge clk_i);
    end while (!elem_bus.ready);
    absorb_element(elem, last);
    elements_sent++;
  endtask

  // Drops valid, waits for every owed result, then lets any element still being
  // folded in (one that closes no array) run to completion.
  task automatic wait_until_idle();
    elem_bus.valid <= 1'b0;
    burst_left = 0;
    while (pending_min_dist.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Only called with the block idle.
  task automatic write_target(input logic [TGT_W-1:0] value);
    cfg_bus.valid        <= 1'b1;
    cfg_bus.target_value <= value;
    do begin
      @(posedge clk_i);
    end while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    target_reg = value;
    target_writes++;
  endtask

  function automatic logic [DATA_W-1:0] pick_element(input fill_style_e style);
    logic [DATA_W-1:0] e;
    case (style)
      FILL_DENSE: begin
        e = '1;
        repeat ($urandom_range(0, 3)) e[$urandom_range(0, DATA_W - 1)] = 1'b0;
      end
      FILL_NARROW: e = DATA_W'($urandom_range(0, 255));
      FILL_MIXED: begin
        case ($urandom_range(0, 4))
          0: e = '0;
          1: e = '1;
          2: e = pick_element(FILL_DENSE);
          3: e = pick_element(FILL_NARROW);
          default: e = DATA_W'($urandom);
        endcase
      end
      default: e = DATA_W'($urandom);
    endcase
    return e;
  endfunction

  function automatic logic [TGT_W-1:0] pick_target();
    logic [TGT_W-1:0] t;
    case ($urandom_range(0, 5))
      0: t = '0;
      1: t = '1;
      2: t = TGT_W'({DATA_W{1'b1}});
      3: t = TGT_W'($urandom_range(0, (1 << DATA_W) - 1));
      4: t = TGT_W'($urandom);
      default: t = TGT_W'($urandom_range(0, 255));
    endcase
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // One-element arrays at both ends of the element range, target still at reset.
  task automatic test_single_element_arrays();
    send_element('0, 1'b1);
    send_element('1, 1'b1);
    wait_until_idle();
  endtask

  // Elements all-ones-but-bit-k for k = 19 down to 0, then all ones: the runs
  // ending at the last element give 21 distinct ANDs, the deepest the set can
  // get. One more element then has to walk the full set.
  task automatic test_full_and_set();
    write_target('1);
    for (int k = DATA_W - 1; k >= 0; k--) begin
      send_element(~(DATA_W'(1) << k), 1'b0);
    end
    send_element('1, 1'b0);
    send_element(DATA_W'(20'h55555), 1'b1);
    wait_until_idle();
  endtask

  // Target changed in the middle of an array: the distance found under the
  // old target has to survive, the new target applies from then on.
  task automatic test_target_change_mid_array();
    write_target(TGT_W'(24'h054321));
    send_element('0, 1'b0);
    wait_until_idle();
    write_target('1);
    send_element('1, 1'b1);
    wait_until_idle();
  endtask

  // Random arrays, mostly short, now and then long. The target is rewritten
  // between phases; a phase may stop inside an array, so target changes also
  // land mid-array.
  task automatic test_random_arrays();
    int sent;
    int arr_len;
    int pos;
    int phase_len;
    fill_style_e style;
    sent = 0;
    arr_len = 0;
    pos = 0;
    style = FILL_UNIFORM;
    while (sent < RANDOM_ITEMS) begin
      phase_len = $urandom_range(60, 250);
      for (int n = 0; n < phase_len && sent < RANDOM_ITEMS; n++) begin
        if (pos == arr_len) begin
          arr_len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
          pos = 0;
          style = fill_style_e'($urandom_range(0, 3));
        end
        send_element(pick_element(style), pos == arr_len - 1);
        pos++;
        sent++;
      end
      wait_until_idle();
      write_target(pick_target());
    end
    // close whatever array is still open
    while (pos < arr_len) begin
      send_element(pick_element(style), pos == arr_len - 1);
      pos++;
    end
    wait_until_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    mismatches = 0;
    elements_sent = 0;
    arrays_closed = 0;
    results_checked = 0;
    target_writes = 0;
    deepest_set = 0;
    burst_left = 0;
    quiet_cycles = 0;
    run_ands.delete();
    best_dist = DIST_MAX;
    target_reg = '0;

    rst_ni                <= 1'b0;
    elem_bus.valid        <= 1'b0;
    elem_bus.element      <= '0;
    elem_bus.end_of_array <= 1'b0;
    cfg_bus.valid         <= 1'b0;
    cfg_bus.target_value  <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_element_arrays();
    test_full_and_set();
    test_target_change_mid_array();
    test_random_arrays();

    $display("Covered %0d elements in %0d arrays, %0d results checked.",
             elements_sent, arrays_closed, results_checked);
    $display("Target written %0d times; deepest AND set %0d entries.",
             target_writes, deepest_set);
    if (mismatches == 0) begin
      $display("closest_subarray_and_to_target: match");
    end else begin
      $display("closest_subarray_and_to_target: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/csat_pkg.sv
design/csat_if.sv
design/csat_ctrl.sv
design/csat_dp.sv
design/closest_subarray_and_to_target.sv
design/csat_chk.sv
dv/tb.sv
